FILE: sv/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants for the market feed packet parser: parser
// phases, result kinds, the result record and a saturating counter helper.
// ----------------------------------------------------------------------------
package mfp_pkg;

	localparam int SYM_W = 40;

	localparam logic [7:0] TYPE_TRADE = 8'h54;
	localparam logic [7:0] TYPE_QUOTE = 8'h51;

	typedef enum logic [8:0] {
		PH_HEADER = 9'b0_0000_0001,
		PH_ULEN   = 9'b0_0000_0010,
		PH_TYPE   = 9'b0_0000_0100,
		PH_SYMBOL = 9'b0_0000_1000,
		PH_LEVEL  = 9'b0_0001_0000,
		PH_SIZE   = 9'b0_0010_0000,
		PH_PRICE  = 9'b0_0100_0000,
		PH_USKIP  = 9'b0_1000_0000,
		PH_PSKIP  = 9'b1_0000_0000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TRADE     = 2'd0,
		KIND_QUOTE     = 2'd1,
		KIND_UNKNOWN   = 2'd2,
		KIND_MALFORMED = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [SYM_W-1:0]  symbol;
		logic [15:0]       level;
		logic [15:0]       qty;
		logic [63:0]       price;
		logic              last;
	} rec_t;

	// Byte counters stop at their maximum instead of wrapping.
	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

FILE: sv/mfp_parser.sv
// ----------------------------------------------------------------------------
// mfp_parser
// Packet and update decoder. Holds the parse state and consumes one byte per
// step, producing at most one result record for that byte.
// ----------------------------------------------------------------------------
module mfp_parser #(
	parameter int SYMBOL_BYTES = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   data_byte,
	output logic         res_valid,
	output mfp_pkg::rec_t res
);
	import mfp_pkg::*;

	localparam logic [15:0] SYM_END = 16'(3 + SYMBOL_BYTES);

	phase_t            phase_q, phase_d;
	logic [15:0]       pkt_len_q, pkt_len_d;
	logic [15:0]       pkt_seen_q, pkt_seen_d;
	logic [15:0]       upd_left_q, upd_left_d;
	logic [15:0]       upd_len_q, upd_len_d;
	logic [15:0]       upd_seen_q, upd_seen_d;
	logic [7:0]        type_q, type_d;
	logic [SYM_W-1:0]  sym_q, sym_d;
	logic [15:0]       lvl_q, lvl_d;
	logic [15:0]       size_q, size_d;
	logic [63:0]       price_q, price_d;

	logic [15:0] pseen_inc, ub, body_end;
	logic        quote, last;
	logic        start_upd, end_pkt, end_upd, clear_all;

	always_comb begin
		phase_d    = phase_q;
		pkt_len_d  = pkt_len_q;
		pkt_seen_d = pkt_seen_q;
		upd_left_d = upd_left_q;
		upd_len_d  = upd_len_q;
		upd_seen_d = upd_seen_q;
		type_d     = type_q;
		sym_d      = sym_q;
		lvl_d      = lvl_q;
		size_d     = size_q;
		price_d    = price_q;
		res_valid  = 1'b0;
		res        = '0;
		start_upd  = 1'b0;
		end_pkt    = 1'b0;
		end_upd    = 1'b0;
		clear_all  = 1'b0;
		pseen_inc  = sat_inc(pkt_seen_q);
		ub         = sat_inc(upd_seen_q);
		quote      = (type_q == TYPE_QUOTE);
		body_end   = quote ? SYM_END + 16'd12 : SYM_END + 16'd10;
		last       = (upd_left_q == 16'd1);

		if (step) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pkt_seen_q < 16'd2) begin
						pkt_len_d = {pkt_len_q[7:0], data_byte};
					end else begin
						upd_left_d = {upd_left_q[7:0], data_byte};
					end
					pkt_seen_d = pseen_inc;
					if (pseen_inc >= 16'd4) begin
						if (upd_left_d != 16'd0) begin
							start_upd = 1'b1;
						end else begin
							if (pkt_len_d < 16'd4) begin
								res_valid = 1'b1;
								res.kind  = KIND_MALFORMED;
								res.last  = 1'b1;
							end
							end_pkt = 1'b1;
						end
					end
				end
				PH_PSKIP: begin
					pkt_seen_d = pseen_inc;
					if (pseen_inc >= pkt_len_q) end_pkt = 1'b1;
				end
				PH_ULEN: begin
					pkt_seen_d = pseen_inc;
					upd_seen_d = ub;
					upd_len_d  = {upd_len_q[7:0], data_byte};
					if (ub >= 16'd2) phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					pkt_seen_d = pseen_inc;
					upd_seen_d = ub;
					type_d     = data_byte;
					if (data_byte == TYPE_TRADE || data_byte == TYPE_QUOTE) begin
						phase_d = PH_SYMBOL;
					end else begin
						res_valid = 1'b1;
						res.kind  = KIND_UNKNOWN;
						res.last  = 1'b1;
						end_pkt   = 1'b1;
					end
				end
				PH_SYMBOL: begin
					pkt_seen_d = pseen_inc;
					upd_seen_d = ub;
					sym_d      = {sym_q[SYM_W-9:0], data_byte};
					if (ub >= SYM_END) phase_d = quote ? PH_LEVEL : PH_SIZE;
				end
				PH_LEVEL: begin
					pkt_seen_d = pseen_inc;
					upd_seen_d = ub;
					lvl_d      = {lvl_q[7:0], data_byte};
					if (ub >= SYM_END + 16'd2) phase_d = PH_SIZE;
				end
				PH_SIZE: begin
					pkt_seen_d = pseen_inc;
					upd_seen_d = ub;
					size_d     = {size_q[7:0], data_byte};
					if (ub >= SYM_END + (quote ? 16'd4 : 16'd2)) phase_d = PH_PRICE;
				end
				PH_PRICE: begin
					pkt_seen_d = pseen_inc;
					upd_seen_d = ub;
					price_d    = {price_q[55:0], data_byte};
					if (ub >= body_end) begin
						res_valid  = 1'b1;
						res.kind   = quote ? KIND_QUOTE : KIND_TRADE;
						if (upd_len_q < ub || (last && pkt_len_q < pseen_inc)) begin
							res.kind = KIND_MALFORMED;
						end
						res.symbol = sym_q;
						res.level  = quote ? lvl_q : 16'd0;
						res.qty    = size_q;
						res.price  = price_d;
						res.last   = last;
						if (ub < upd_len_q) begin
							phase_d = PH_USKIP;
						end else begin
							end_upd = 1'b1;
						end
					end
				end
				PH_USKIP: begin
					pkt_seen_d = pseen_inc;
					upd_seen_d = ub;
					if (ub >= upd_len_q) end_upd = 1'b1;
				end
				default: begin
					clear_all = 1'b1;
				end
			endcase
		end

		if (end_upd) begin
			upd_left_d = upd_left_q - 16'd1;
			if (upd_left_d != 16'd0) begin
				start_upd = 1'b1;
			end else begin
				end_pkt = 1'b1;
			end
		end

		if (start_upd) begin
			phase_d    = PH_ULEN;
			upd_len_d  = '0;
			upd_seen_d = '0;
			type_d     = '0;
			sym_d      = '0;
			lvl_d      = '0;
			size_d     = '0;
			price_d    = '0;
		end

		if (end_pkt) begin
			if (pkt_seen_d < pkt_len_d) begin
				phase_d = PH_PSKIP;
			end else begin
				phase_d    = PH_HEADER;
				pkt_len_d  = '0;
				pkt_seen_d = '0;
				upd_left_d = '0;
			end
		end

		if (clear_all) begin
			phase_d    = PH_HEADER;
			pkt_len_d  = '0;
			pkt_seen_d = '0;
			upd_left_d = '0;
			upd_len_d  = '0;
			upd_seen_d = '0;
			type_d     = '0;
			sym_d      = '0;
			lvl_d      = '0;
			size_d     = '0;
			price_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pkt_len_q  <= '0;
			pkt_seen_q <= '0;
			upd_left_q <= '0;
			upd_len_q  <= '0;
			upd_seen_q <= '0;
			type_q     <= '0;
			sym_q      <= '0;
			lvl_q      <= '0;
			size_q     <= '0;
			price_q    <= '0;
		end else begin
			phase_q    <= phase_d;
			pkt_len_q  <= pkt_len_d;
			pkt_seen_q <= pkt_seen_d;
			upd_left_q <= upd_left_d;
			upd_len_q  <= upd_len_d;
			upd_seen_q <= upd_seen_d;
			type_q     <= type_d;
			sym_q      <= sym_d;
			lvl_q      <= lvl_d;
			size_q     <= size_d;
			price_q    <= price_d;
		end
	end

	// An unknown type always ends the packet's decoding.
	a_unknown_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_UNKNOWN |-> res.last)
		else $error("unknown type result without packet end");

	// Trades never report a price level.
	a_trade_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_TRADE |-> res.level == 16'd0)
		else $error("trade result with nonzero level");

	// Nothing is emitted while skipping to the end of a packet.
	a_pskip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PSKIP |-> !res_valid)
		else $error("result emitted during packet skip");

endmodule

FILE: sv/mfp_result_reg.sv
// ----------------------------------------------------------------------------
// mfp_result_reg
// Output register holding one result record until the downstream side takes
// it.
// ----------------------------------------------------------------------------
module mfp_result_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          res_valid,
	input  mfp_pkg::rec_t res,
	input  logic          out_ready,
	output logic          out_valid,
	output mfp_pkg::rec_t out_rec
);
	import mfp_pkg::*;

	logic valid_q;
	rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			rec_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_rec   = rec_q;

	// A loaded result shows up on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && res_valid |=> out_valid)
		else $error("loaded result not presented");

endmodule

FILE: sv/market_feed_packet_parser_top.sv
// ----------------------------------------------------------------------------
// market_feed_packet_parser_top
// Decodes a byte stream of market data packets into trade, quote, unknown and malformed records.
// ----------------------------------------------------------------------------
// The input register takes each byte at its transfer; the parse step then
// decodes it and loads any result it completes into the result register,
// which drives out_valid. The step waits while that register is stalled.
// Throughput: one byte per cycle while the result register is empty or
// being drained; bytes that yield no result still take a parse step.
// Reset: arst_n clears the parse state to the start of a packet header and
// empties both the input and result registers.
// ----------------------------------------------------------------------------
module market_feed_packet_parser_top #(
	parameter int SYMBOL_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [39:0] symbol,
	output logic [15:0] price_level,
	output logic [15:0] quantity,
	output logic [63:0] price,
	output logic        packet_end
);
	import mfp_pkg::*;

	// Input register: one byte waits here for the parse step.
	logic       valid_s1;
	logic [7:0] data_s1;

	// The parse step runs when a byte is waiting and the result register is
	// empty or is being drained in this cycle. Bytes that produce no result
	// still need that slot free, which keeps the control simple.
	logic advance;
	logic res_valid;
	rec_t res;
	rec_t out_rec;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
		end
	end

	mfp_parser #(
		.SYMBOL_BYTES(SYMBOL_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mfp_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_rec   (out_rec)
	);

	assign record_kind = out_rec.kind;
	assign symbol      = out_rec.symbol;
	assign price_level = out_rec.level;
	assign quantity    = out_rec.qty;
	assign price       = out_rec.price;
	assign packet_end  = out_rec.last;

	// A waiting byte with a stalled result must hold off new transfers.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while parse step is stalled");

endmodule
